### rtl/fpa_pkg.sv
// Shared types, opcodes and status codes of the fixed-point unit.
`default_nettype none
package fpa_pkg;
	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_LT = 4'd4;
	localparam logic [3:0] OP_GT = 4'd5;
	localparam logic [3:0] OP_LE = 4'd6;
	localparam logic [3:0] OP_GE = 4'd7;
	localparam logic [3:0] OP_EQ = 4'd8;
	localparam logic [3:0] OP_NE = 4'd9;
	localparam logic [3:0] OP_MIN = 4'd10;
	localparam logic [3:0] OP_MAX = 4'd11;
	localparam logic [3:0] OP_INC = 4'd12;
	localparam logic [3:0] OP_DEC = 4'd13;
	localparam logic [3:0] OP_FROM_INT = 4'd14;
	localparam logic [3:0] OP_TO_INT = 4'd15;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	localparam int WORD_W = 32;
	localparam int QUOT_W = 64;

	// Request as presented to the first stage.
	typedef struct packed {
		logic [3:0] op;
		logic signed [WORD_W-1:0] a;
		logic signed [WORD_W-1:0] b;
	} req_t;

	// Result computed in the first stage for ops other than multiply and divide.
	typedef struct packed {
		logic [WORD_W-1:0] res;
		logic flag;
		logic [1:0] status;
	} res_t;

	// Division working set handed from cell to cell.
	typedef struct packed {
		logic [QUOT_W-1:0] rem;
		logic [QUOT_W-1:0] quo;
		logic [WORD_W-1:0] dvs;
		logic neg;
	} div_t;
endpackage
`default_nettype wire

### rtl/fpa_front.sv
// First stage: all ops other than multiply and divide, and the multiply product register.
`default_nettype none
module fpa_front #(
	parameter int FRAC_BITS = 8
) (
	input wire logic clk,
	input wire logic en,
	input wire fpa_pkg::req_t req,
	output fpa_pkg::res_t res_s1,
	output logic [63:0] prod_s1,
	output logic mneg_s1
);
	localparam logic [31:0] POS = 32'h7fffffff;
	localparam logic [31:0] NEG = 32'h80000000;

	logic signed [32:0] sum, dif, inc, dec;
	logic [31:0] ma, mb;
	logic [31+FRAC_BITS:0] fi;
	fpa_pkg::res_t r;

	function automatic logic [33:0] sat33(input logic signed [32:0] v);
		if (v > 33'sd2147483647) sat33 = {fpa_pkg::ST_OVF, POS};
		else if (v < -33'sd2147483648) sat33 = {fpa_pkg::ST_OVF, NEG};
		else sat33 = {fpa_pkg::ST_OK, v[31:0]};
	endfunction

	always_comb begin
		sum = 33'(req.a) + 33'(req.b);
		dif = 33'(req.a) - 33'(req.b);
		inc = 33'(req.a) + 33'sd1;
		dec = 33'(req.a) - 33'sd1;
		ma = req.a[31] ? 32'(-req.a) : req.a;
		mb = req.b[31] ? 32'(-req.b) : req.b;
		fi = {FRAC_BITS'(0), ma} << FRAC_BITS;
		r = '0;
		case (req.op)
			fpa_pkg::OP_ADD: {r.status, r.res} = sat33(sum);
			fpa_pkg::OP_SUB: {r.status, r.res} = sat33(dif);
			fpa_pkg::OP_LT: r.flag = req.a < req.b;
			fpa_pkg::OP_GT: r.flag = req.a > req.b;
			fpa_pkg::OP_LE: r.flag = req.a <= req.b;
			fpa_pkg::OP_GE: r.flag = req.a >= req.b;
			fpa_pkg::OP_EQ: r.flag = req.a == req.b;
			fpa_pkg::OP_NE: r.flag = req.a != req.b;
			fpa_pkg::OP_MIN: r.res = (req.a < req.b) ? req.a : req.b;
			fpa_pkg::OP_MAX: r.res = (req.a > req.b) ? req.a : req.b;
			fpa_pkg::OP_INC: {r.status, r.res} = sat33(inc);
			fpa_pkg::OP_DEC: {r.status, r.res} = sat33(dec);
			fpa_pkg::OP_FROM_INT: begin
				if (req.a[31]) begin
					if (fi > {FRAC_BITS'(0), NEG}) begin
						r.res = NEG;
						r.status = fpa_pkg::ST_OVF;
					end else r.res = 32'(-fi);
				end else if (fi > {FRAC_BITS'(0), POS}) begin
					r.res = POS;
					r.status = fpa_pkg::ST_OVF;
				end else r.res = fi[31:0];
			end
			fpa_pkg::OP_TO_INT: r.res = 32'(req.a >>> FRAC_BITS);
			default: r = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s1 <= r;
			prod_s1 <= 64'(ma) * 64'(mb);
			mneg_s1 <= req.a[31] ^ req.b[31];
		end
	end
endmodule
`default_nettype wire

### rtl/fpa_div_cell.sv
// One restoring-division cell: retires one quotient bit per cycle while enabled.
`default_nettype none
module fpa_div_cell (
	input wire logic clk,
	input wire logic en,
	input wire fpa_pkg::div_t din,
	output fpa_pkg::div_t dout
);
	logic [64:0] trial;
	logic [63:0] rsh;
	logic [64:0] diff;
	logic fits;

	always_comb begin
		trial = {din.rem, din.quo[63]};
		rsh = trial[63:0];
		diff = trial - 65'(din.dvs);
		fits = !diff[64];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout.rem <= fits ? diff[63:0] : rsh;
			dout.quo <= {din.quo[62:0], fits};
			dout.dvs <= din.dvs;
			dout.neg <= din.neg;
		end
	end
endmodule
`default_nettype wire

### rtl/fixed_point_alu.sv
// Top level of the fixed-point ALU: front stage, divider cell chain, rounding and output.
// All ops share one depth to out_valid: front-stage, per-cell and output registers.
// One request per cycle unless stalled; the one-bit division cells are fully pipelined.
// The whole pipeline advances only when the output is not stalled or holds a bubble.
// Reset (arst_n low, asynchronous) clears all valid bits; payload registers are not reset.
`default_nettype none
module fixed_point_alu #(
	parameter int FRAC_BITS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [3:0] op,
	input wire logic signed [31:0] operand_a,
	input wire logic signed [31:0] operand_b,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [31:0] result,
	output logic flag,
	output logic [1:0] status
);
	localparam int NCELL = 32 + FRAC_BITS;
	localparam int DEPTH = NCELL + 2;

	fpa_pkg::req_t req;
	fpa_pkg::res_t res_s1;
	logic [63:0] prod_s1;
	logic mneg_s1;
	logic en;
	logic [DEPTH-1:0] vld_q;
	fpa_pkg::res_t side0;
	fpa_pkg::res_t side_q [NCELL+1];
	logic [3:0] op_q [NCELL+1];
	logic sgn_q [NCELL+1];
	logic az_q [NCELL+1];
	logic bz_q [NCELL+1];
	fpa_pkg::div_t chain [NCELL+1];
	fpa_pkg::div_t din0;
	logic [31:0] mulq, bmag, amag;
	logic [63:0] mulr;
	logic [63:0] dq;
	logic dround;
	fpa_pkg::res_t fin;

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	assign req = '{op: op, a: operand_a, b: operand_b};

	fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .en(en), .req(req),
		.res_s1(res_s1), .prod_s1(prod_s1), .mneg_s1(mneg_s1)
	);

	assign amag = operand_a[31] ? 32'(-operand_a) : operand_a;
	assign bmag = operand_b[31] ? 32'(-operand_b) : operand_b;

	// Dividend is |a| << FRAC_BITS left-aligned in a 64-bit shift word.
	always_comb begin
		din0.rem = '0;
		din0.quo = {amag, 32'd0} >> (32 - FRAC_BITS);
		din0.quo = din0.quo << (64 - NCELL);
		din0.dvs = bmag;
		din0.neg = operand_a[31] ^ operand_b[31];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chain[0] <= din0;
			op_q[0] <= op;
			sgn_q[0] <= operand_a[31];
			az_q[0] <= operand_a == 32'sd0;
			bz_q[0] <= operand_b == 32'sd0;
		end
	end

	// Multiply rounding is registered into the side path right after the product.
	assign mulr = prod_s1 + (64'd1 << (FRAC_BITS - 1));
	assign mulq = 32'(mulr >> FRAC_BITS);
	always_comb begin
		side0 = res_s1;
		if (op_q[0] == fpa_pkg::OP_MUL) begin
			side0.flag = 1'b0;
			side0.status = fpa_pkg::ST_OK;
			if ((mulr >> FRAC_BITS) > (mneg_s1 ? 64'h80000000 : 64'h7fffffff)) begin
				side0.res = mneg_s1 ? 32'h80000000 : 32'h7fffffff;
				side0.status = fpa_pkg::ST_OVF;
			end else side0.res = mneg_s1 ? 32'(-mulq) : mulq;
		end
	end
	assign side_q[0] = side0;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		fpa_div_cell u_cell (.clk(clk), .en(en), .din(chain[i]), .dout(chain[i+1]));
		fpa_pkg::res_t sd;
		always_ff @(posedge clk) begin
			if (en) begin
				sd <= side_q[i];
				op_q[i+1] <= op_q[i];
				sgn_q[i+1] <= sgn_q[i];
				az_q[i+1] <= az_q[i];
				bz_q[i+1] <= bz_q[i];
			end
		end
		assign side_q[i+1] = sd;
	end

	// Round half away from zero: bump when 2*rem >= divisor.
	always_comb begin
		dq = chain[NCELL].quo;
		dround = {chain[NCELL].rem, 1'b0} >= 65'(chain[NCELL].dvs);
		dq = dq + 64'(dround);
		fin = side_q[NCELL];
		if (op_q[NCELL] == fpa_pkg::OP_DIV) begin
			fin.flag = 1'b0;
			if (bz_q[NCELL]) begin
				fin.status = fpa_pkg::ST_DIV0;
				fin.res = az_q[NCELL] ? 32'd0 : (sgn_q[NCELL] ? 32'h80000000 : 32'h7fffffff);
			end else if (dq > (chain[NCELL].neg ? 64'h80000000 : 64'h7fffffff)) begin
				fin.status = fpa_pkg::ST_OVF;
				fin.res = chain[NCELL].neg ? 32'h80000000 : 32'h7fffffff;
			end else begin
				fin.status = fpa_pkg::ST_OK;
				fin.res = chain[NCELL].neg ? 32'(-dq) : dq[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result <= fin.res;
			flag <= fin.flag;
			status <= fin.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end
	assign out_valid = vld_q[DEPTH-1];

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result) && $stable(status))
		else $error("stalled result changed");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3) else $error("bad status code");
	a_flag_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flag |-> status == fpa_pkg::ST_OK && result == 32'sd0)
		else $error("flag with nonzero result");
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid) else $error("stall without pending result");
endmodule
`default_nettype wire
